FILE: sv/mfd_pkg.sv
package mfd_pkg;

   // Frame and datapath widths
   localparam int unsigned FRAME_W     = 48;
   localparam int unsigned LEN_W       = 4;
   localparam int unsigned RAW_W       = 16;
   localparam int unsigned VAL_W       = 32;
   // Wide signed working width for sums, rounding and saturation
   localparam int unsigned DIV_NUM_W   = 41;
   localparam int unsigned DIV_MAG_W   = 40;
   localparam int unsigned DIV_DIGIT_W = 8;
   localparam int unsigned DIV_STEPS   = DIV_MAG_W / DIV_DIGIT_W;
   localparam int unsigned DIV_D_W     = 5;

   localparam logic [LEN_W-1:0]   FRAME_LEN_OK = LEN_W'(6);
   localparam logic [DIV_D_W-1:0] SMOOTH_DEN   = DIV_D_W'(10);

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      CSR_EXPECTED_ID     = 3'd0,
      CSR_REVERSE_DIR     = 3'd1,
      CSR_POSITION_STEP   = 3'd2,
      CSR_POSITION_OFFSET = 3'd3,
      CSR_VELOCITY_STEP   = 3'd4,
      CSR_VELOCITY_OFFSET = 3'd5,
      CSR_CURRENT_STEP    = 3'd6,
      CSR_CURRENT_OFFSET  = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS_GO,
      ST_POS_WAIT,
      ST_VEL_GO,
      ST_VEL_WAIT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_CUR_GO,
      ST_CUR_WAIT,
      ST_SMOOTH_GO,
      ST_SMOOTH_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0]   frame_len;
      logic [FRAME_W-1:0] frame_data;
   } req_type;

   typedef struct packed {
      logic                    accepted;
      logic                    recovered;
      logic [7:0]              node_id;
      logic signed [VAL_W-1:0] position;
      logic signed [VAL_W-1:0] prior_position;
      logic signed [VAL_W-1:0] velocity;
      logic signed [VAL_W-1:0] current;
   } rsp_type;

   // One operation for the shared scaling unit
   typedef struct packed {
      logic [RAW_W-1:0]        raw;
      logic [VAL_W-1:0]        step;
      logic signed [VAL_W-1:0] offset;
      logic                    rev;
   } scale_op_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [DIV_NUM_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > DIV_NUM_W'(VAL_MAX)) begin
         r = VAL_MAX;
      end else if (v < DIV_NUM_W'(VAL_MIN)) begin
         r = VAL_MIN;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/mfd_scaler.sv
module mfd_scaler
   import mfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  scale_op_type            op,
   output logic                    done,
   output logic signed [VAL_W-1:0] result
);

   localparam int unsigned PROD_W = RAW_W + VAL_W;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(32768);

   logic                    v1_ff, v2_ff, v3_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [VAL_W-1:0] sum_ff;
   logic signed [VAL_W-1:0] out_ff;

   logic [PROD_W:0]             rnd;
   logic signed [DIV_NUM_W-1:0] sum_wide;
   logic signed [DIV_NUM_W-1:0] neg_wide;

   always_comb begin
      rnd      = {1'b0, prod_ff} + ROUND_HALF;
      sum_wide = $signed(DIV_NUM_W'(rnd[PROD_W:16]))
               + {{(DIV_NUM_W-VAL_W){op.offset[VAL_W-1]}}, op.offset};
      neg_wide = -{{(DIV_NUM_W-VAL_W){sum_ff[VAL_W-1]}}, sum_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op.raw) * PROD_W'(op.step);
      sum_ff  <= sat32(sum_wide);
      out_ff  <= op.rev ? sat32(neg_wide) : sum_ff;
   end

   assign done   = v3_ff;
   assign result = out_ff;

endmodule

FILE: sv/mfd_divider.sv
module mfd_divider
   import mfd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIV_NUM_W-1:0] numer,
   input  logic [DIV_D_W-1:0]          divisor,
   output logic                        done,
   output logic signed [DIV_NUM_W-1:0] quot
);

   localparam int unsigned REM_W = DIV_D_W - 1;
   localparam int unsigned CNT_W = $clog2(DIV_STEPS);

   logic                 run_ff, done_ff, neg_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_MAG_W-1:0] mag_ff, mag_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_D_W-1:0]   d_ff;

   logic [DIV_NUM_W-1:0] abs_n;
   logic [DIV_MAG_W-1:0] start_mag;

   // Restoring division, one quotient byte per cycle, dividend shifted out at the top
   always_comb begin
      logic [REM_W-1:0]       r;
      logic [DIV_D_W-1:0]     partial;
      logic [DIV_DIGIT_W-1:0] digit;
      r     = rem_ff;
      digit = '0;
      for (int k = 0; k < DIV_DIGIT_W; k++) begin
         partial = {r, mag_ff[DIV_MAG_W-1-k]};
         if (partial >= d_ff) begin
            digit[DIV_DIGIT_W-1-k] = 1'b1;
            r = REM_W'(partial - d_ff);
         end else begin
            r = partial[REM_W-1:0];
         end
      end
      rem_in = r;
      mag_in = {mag_ff[DIV_MAG_W-DIV_DIGIT_W-1:0], digit};
   end

   always_comb begin
      abs_n     = numer[DIV_NUM_W-1] ? -numer : numer;
      // Bias by half the divisor: rounds to nearest, ties away from zero
      start_mag = abs_n[DIV_MAG_W-1:0] + DIV_MAG_W'(divisor >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= start_mag;
         rem_ff <= '0;
         d_ff   <= divisor;
         neg_ff <= numer[DIV_NUM_W-1];
      end else if (run_ff) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

endmodule

FILE: sv/mfd_vel_history.sv
module mfd_vel_history
   import mfd_pkg::*;
#(
   parameter int unsigned DEPTH = 5
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   input  logic signed [VAL_W-1:0]                  sample,
   output logic signed [VAL_W+$clog2(DEPTH)-1:0]    sum
);

   localparam int unsigned SUM_W = VAL_W + $clog2(DEPTH);

   logic signed [VAL_W-1:0] hist_ff [DEPTH];
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   // Running sum: add the new sample, drop the oldest
   assign sum_in = sum_ff + {{(SUM_W-VAL_W){sample[VAL_W-1]}}, sample}
                 - {{(SUM_W-VAL_W){hist_ff[0][VAL_W-1]}}, hist_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (push) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            hist_ff[i] <= hist_ff[i+1];
         end
         hist_ff[DEPTH-1] <= sample;
         sum_ff           <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

FILE: sv/motor_feedback_frame_decoder.sv
// Motor feedback frame decoder.
// Input channel req_*: one received frame per item (length and six data bytes).
// Result channel rsp_*: exactly one result item per input item. A frame with a
// bad length or id gives an all-zero result and leaves the state untouched.
// Configuration port csr_*: one register written per cycle with csr_we high;
// write only while no frame is in flight.
// The block takes one frame at a time. An accepted frame passes through a
// sequencer running three scalings through one shared multiply/round/saturate
// pipe and two rounded divisions through one byte-per-cycle divider; a rejected
// frame goes straight to the output step.
// Reset (synchronous) clears the sequencer, configuration and stored position,
// the velocity history and the smoothed current, and marks the motor offline.
// When the receiver stalls, the finished result holds in the output register;
// a new frame may still be accepted and worked on, and it waits at the last
// step until the output register is free.
module motor_feedback_frame_decoder
   import mfd_pkg::*;
#(
   parameter int unsigned AVG_DEPTH = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned SUM_W = VAL_W + $clog2(AVG_DEPTH);

   // Configuration registers
   logic [7:0]              expected_id_ff;
   logic                    reverse_dir_ff;
   logic [VAL_W-1:0]        position_step_ff, velocity_step_ff, current_step_ff;
   logic signed [VAL_W-1:0] position_offset_ff, velocity_offset_ff, current_offset_ff;

   state_type               state_ff, state_in;
   req_type                 frame_ff;
   logic                    ok_ff;
   logic signed [VAL_W-1:0] pos_ff, vel_ff, cur_new_ff, cur_ff;
   logic signed [VAL_W-1:0] position_reg_ff, current_reg_ff;
   logic                    offline_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;

   logic                        frame_ok;
   logic                        out_free;
   logic                        scl_start, scl_done;
   scale_op_type                scl_op;
   logic signed [VAL_W-1:0]     scl_result;
   logic                        div_start, div_done;
   logic signed [DIV_NUM_W-1:0] div_numer, div_quot;
   logic [DIV_D_W-1:0]          div_divisor;
   logic                        hist_push;
   logic signed [SUM_W-1:0]     vel_sum;
   logic signed [DIV_NUM_W-1:0] cur_wide;

   mfd_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (scl_start),
      .op     (scl_op),
      .done   (scl_done),
      .result (scl_result)
   );

   mfd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (div_numer),
      .divisor (div_divisor),
      .done    (div_done),
      .quot    (div_quot)
   );

   mfd_vel_history #(
      .DEPTH (AVG_DEPTH)
   ) u_history (
      .clock  (clock),
      .reset  (reset),
      .push   (hist_push),
      .sample (scl_result),
      .sum    (vel_sum)
   );

   assign frame_ok = (req_data.frame_len == FRAME_LEN_OK)
                  && ((expected_id_ff == 8'd0)
                      || (req_data.frame_data[47:40] == expected_id_ff));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // New current sample, held wide so 9 * new + previous does not wrap
   assign cur_wide = {{(DIV_NUM_W-VAL_W){cur_new_ff[VAL_W-1]}}, cur_new_ff};

   always_comb begin
      state_in    = state_ff;
      scl_start   = 1'b0;
      div_start   = 1'b0;
      hist_push   = 1'b0;
      scl_op.raw    = frame_ff.frame_data[39:24];
      scl_op.step   = position_step_ff;
      scl_op.offset = position_offset_ff;
      scl_op.rev    = reverse_dir_ff;
      div_numer   = {{(DIV_NUM_W-SUM_W){vel_sum[SUM_W-1]}}, vel_sum};
      div_divisor = DIV_D_W'(AVG_DEPTH);

      case (state_ff)
         ST_VEL_GO, ST_VEL_WAIT: begin
            scl_op.raw    = RAW_W'(frame_ff.frame_data[23:12]);
            scl_op.step   = velocity_step_ff;
            scl_op.offset = velocity_offset_ff;
         end
         ST_CUR_GO, ST_CUR_WAIT: begin
            scl_op.raw    = RAW_W'(frame_ff.frame_data[11:0]);
            scl_op.step   = current_step_ff;
            scl_op.offset = current_offset_ff;
         end
         ST_SMOOTH_GO, ST_SMOOTH_WAIT: begin
            div_numer   = (cur_wide <<< 3) + cur_wide
                        + {{(DIV_NUM_W-VAL_W){current_reg_ff[VAL_W-1]}}, current_reg_ff};
            div_divisor = SMOOTH_DEN;
         end
         default: begin
         end
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = frame_ok ? ST_POS_GO : ST_OUT;
            end
         end
         ST_POS_GO: begin
            scl_start = 1'b1;
            state_in  = ST_POS_WAIT;
         end
         ST_POS_WAIT: begin
            if (scl_done) state_in = ST_VEL_GO;
         end
         ST_VEL_GO: begin
            scl_start = 1'b1;
            state_in  = ST_VEL_WAIT;
         end
         ST_VEL_WAIT: begin
            if (scl_done) begin
               hist_push = 1'b1;
               state_in  = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            div_start = 1'b1;
            state_in  = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) state_in = ST_CUR_GO;
         end
         ST_CUR_GO: begin
            scl_start = 1'b1;
            state_in  = ST_CUR_WAIT;
         end
         ST_CUR_WAIT: begin
            if (scl_done) state_in = ST_SMOOTH_GO;
         end
         ST_SMOOTH_GO: begin
            div_start = 1'b1;
            state_in  = ST_SMOOTH_WAIT;
         end
         ST_SMOOTH_WAIT: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         offline_ff         <= 1'b1;
         position_reg_ff    <= '0;
         current_reg_ff     <= '0;
         expected_id_ff     <= '0;
         reverse_dir_ff     <= 1'b0;
         position_step_ff   <= '0;
         position_offset_ff <= '0;
         velocity_step_ff   <= '0;
         velocity_offset_ff <= '0;
         current_step_ff    <= '0;
         current_offset_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_OUT && out_free && ok_ff) begin
            offline_ff      <= 1'b0;
            position_reg_ff <= pos_ff;
            current_reg_ff  <= cur_ff;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_EXPECTED_ID:     expected_id_ff     <= csr_wdata[7:0];
               CSR_REVERSE_DIR:     reverse_dir_ff     <= csr_wdata[0];
               CSR_POSITION_STEP:   position_step_ff   <= csr_wdata;
               CSR_POSITION_OFFSET: position_offset_ff <= csr_wdata;
               CSR_VELOCITY_STEP:   velocity_step_ff   <= csr_wdata;
               CSR_VELOCITY_OFFSET: velocity_offset_ff <= csr_wdata;
               CSR_CURRENT_STEP:    current_step_ff    <= csr_wdata;
               CSR_CURRENT_OFFSET:  current_offset_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath captures, no reset needed
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         frame_ff <= req_data;
         ok_ff    <= frame_ok;
      end
      if (state_ff == ST_POS_WAIT && scl_done) pos_ff <= scl_result;
      if (state_ff == ST_AVG_WAIT && div_done) vel_ff <= sat32(div_quot);
      if (state_ff == ST_CUR_WAIT && scl_done) cur_new_ff <= scl_result;
      if (state_ff == ST_SMOOTH_WAIT && div_done) cur_ff <= sat32(div_quot);
      if (state_ff == ST_OUT && out_free) begin
         if (ok_ff) begin
            rsp_ff.accepted       <= 1'b1;
            rsp_ff.recovered      <= offline_ff;
            rsp_ff.node_id        <= frame_ff.frame_data[47:40];
            rsp_ff.position       <= pos_ff;
            rsp_ff.prior_position <= position_reg_ff;
            rsp_ff.velocity       <= vel_ff;
            rsp_ff.current        <= cur_ff;
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: verif/motor_feedback_frame_decoder_test.sv
module motor_feedback_frame_decoder_test
   import mfd_pkg::*;
();

   localparam int HIST_DEPTH  = 5;
   localparam int PHASE_ITEMS = 295;
   localparam int CYCLE_LIMIT = 600000;

   // Predicts the result for each frame sent (all zero when rejected) and checks results in order
   class feedback_scoreboard;
      bit [7:0]  expected_id;
      bit        reverse;
      bit [31:0] pos_step;
      bit [31:0] vel_step;
      bit [31:0] cur_step;
      int        pos_offset;
      int        vel_offset;
      int        cur_offset;
      int        position_reg;
      int        speed_history[HIST_DEPTH];
      int        current_reg;
      bit        offline;
      rsp_type   predicted_results[$];
      int        errors;
      int        checked;

      function new();
         offline = 1'b1;
      endfunction

      function int clamp32(longint v);
         if (v > longint'(VAL_MAX)) begin
            return VAL_MAX;
         end
         if (v < longint'(VAL_MIN)) begin
            return VAL_MIN;
         end
         return int'(v);
      endfunction

      // Round to nearest, ties away from zero
      function longint round_div(longint n, longint d);
         if (n >= 0) begin
            return (n + d / 2) / d;
         end
         return -((-n + d / 2) / d);
      endfunction

      function int scale_raw(bit [15:0] raw, bit [31:0] step, int offset);
         longint unsigned prod;
         int              v;
         prod = 64'(raw) * 64'(step);
         v = clamp32(longint'((prod + 64'h8000) >> 16) + longint'(offset));
         if (reverse) begin
            v = clamp32(-longint'(v));
         end
         return v;
      endfunction

      function void write_register(csr_index_type idx, bit [31:0] value);
         case (idx)
            CSR_EXPECTED_ID:     expected_id = value[7:0];
            CSR_REVERSE_DIR:     reverse     = value[0];
            CSR_POSITION_STEP:   pos_step    = value;
            CSR_POSITION_OFFSET: pos_offset  = int'(value);
            CSR_VELOCITY_STEP:   vel_step    = value;
            CSR_VELOCITY_OFFSET: vel_offset  = int'(value);
            CSR_CURRENT_STEP:    cur_step    = value;
            CSR_CURRENT_OFFSET:  cur_offset  = int'(value);
            default: ;
         endcase
      endfunction

      function void note_frame(req_type f);
         rsp_type  e;
         bit [7:0] id;
         int       vel_sample;
         int       cur_new;
         longint   sum;
         int       i;
         e  = '0;
         id = f.frame_data[47:40];
         if (f.frame_len == FRAME_LEN_OK && (expected_id == 8'd0 || id == expected_id)) begin
            e.accepted       = 1'b1;
            e.recovered      = offline;
            offline          = 1'b0;
            e.node_id        = id;
            e.prior_position = position_reg;
            position_reg     = scale_raw(f.frame_data[39:24], pos_step, pos_offset);
            e.position       = position_reg;

            vel_sample = scale_raw(16'(f.frame_data[23:12]), vel_step, vel_offset);
            for (i = 0; i < HIST_DEPTH - 1; i++) begin
               speed_history[i] = speed_history[i + 1];
            end
            speed_history[HIST_DEPTH - 1] = vel_sample;
            sum = 0;
            for (i = 0; i < HIST_DEPTH; i++) begin
               sum += longint'(speed_history[i]);
            end
            e.velocity = clamp32(round_div(sum, HIST_DEPTH));

            cur_new     = scale_raw(16'(f.frame_data[11:0]), cur_step, cur_offset);
            current_reg = clamp32(round_div(9 * longint'(cur_new) + longint'(current_reg), 10));
            e.current   = current_reg;
         end
         predicted_results.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         checked++;
         if (predicted_results.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("result %0d arrived with no frame outstanding", checked);
            end
            return;
         end
         e = predicted_results.pop_front();
         if (got.accepted !== e.accepted || got.recovered !== e.recovered ||
             got.node_id !== e.node_id || got.position !== e.position ||
             got.prior_position !== e.prior_position || got.velocity !== e.velocity ||
             got.current !== e.current) begin
            errors++;
            if (errors <= 10) begin
               $display("result %0d expected: acc %0b rec %0b id %h pos %0d prior %0d vel %0d cur %0d",
                        checked, e.accepted, e.recovered, e.node_id, e.position,
                        e.prior_position, e.velocity, e.current);
               $display("result %0d actual:   acc %0b rec %0b id %h pos %0d prior %0d vel %0d cur %0d",
                        checked, got.accepted, got.recovered, got.node_id, got.position,
                        got.prior_position, got.velocity, got.current);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   feedback_scoreboard sb;
   int sender_idle_pct    = 10;
   int receiver_stall_pct = 72;

   motor_feedback_frame_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[motor_feedback_frame_decoder] ERROR");
      $finish;
   end

   // Result side: take results when not stalling, then pick the next stall
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   function automatic bit [31:0] pick_step();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(0, 32'h0010_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic bit [31:0] pick_offset();
      case ($urandom_range(0, 5))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return 32'd0;
         3, 4:    return 32'($urandom_range(0, 400000)) - 32'd200000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_frame(bit well_formed);
      req_type f;
      f.frame_data = 48'({$urandom, $urandom});
      f.frame_len  = FRAME_LEN_OK;
      if (well_formed) begin
         if (sb.expected_id != 8'd0) begin
            f.frame_data[47:40] = sb.expected_id;
         end
         case ($urandom_range(0, 7))
            0:       f.frame_data[39:0] = '0;
            1:       f.frame_data[39:0] = '1;
            default: ;
         endcase
      end else begin
         // random length (may still be six), or a length of six with whatever id came out
         case ($urandom_range(0, 2))
            0:       f.frame_len = 4'($urandom);
            1:       f.frame_len = 4'($urandom_range(0, 8));
            default: ;
         endcase
      end
      return f;
   endfunction

   task automatic send_frame(req_type f);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_frame(f);
   endtask

   // Hold the sender until every outstanding result has been taken
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.predicted_results.size() != 0);
   endtask

   task automatic drain();
      wait_results();
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic program_registers(bit [31:0] id, bit [31:0] rev,
                                    bit [31:0] ps, bit [31:0] po,
                                    bit [31:0] vs, bit [31:0] vo,
                                    bit [31:0] cs, bit [31:0] co);
      write_csr(CSR_EXPECTED_ID, id);
      write_csr(CSR_REVERSE_DIR, rev);
      write_csr(CSR_POSITION_STEP, ps);
      write_csr(CSR_POSITION_OFFSET, po);
      write_csr(CSR_VELOCITY_STEP, vs);
      write_csr(CSR_VELOCITY_OFFSET, vo);
      write_csr(CSR_CURRENT_STEP, cs);
      write_csr(CSR_CURRENT_OFFSET, co);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i == count / 2 || $urandom_range(0, 199) == 0) begin
            wait_results();
         end
         send_frame(make_frame($urandom_range(0, 99) < 80));
      end
   endtask

   initial begin
      int phase;
      sb = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_EXPECTED_ID;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset registers: any id goes, first good frame ends offline
      send_frame({4'd6, 48'h5A_1234_5678_9A});
      send_frame({4'd5, 48'h5A_1234_5678_9A});
      drain();

      // id filter, saturation at both ends
      program_registers(32'h7F, 32'd0, 32'hFFFF_FFFF, VAL_MAX,
                        32'h0001_0000, -32'sd1000, 32'hFFFF_FFFF, VAL_MIN);
      send_frame({4'd6, 48'h7F_FFFF_FFFF_FF});
      send_frame({4'd6, 48'h7F_0000_0000_00});
      send_frame({4'd6, 48'h80_FFFF_FFFF_FF});
      send_frame({4'd0, 48'h7F_1234_5678_9A});
      send_frame({4'd8, 48'h7F_1234_5678_9A});
      send_frame({4'd15, 48'h7F_1234_5678_9A});
      send_frame({4'd7, 48'h7F_1234_5678_9A});
      send_frame({4'd6, 48'h7F_8000_8008_00});
      send_frame({4'd6, 48'h7F_1234_5678_9A});
      drain();

      // reversal of the most negative value saturates
      program_registers(32'd0, 32'd1, 32'd0, VAL_MIN, 32'd0, VAL_MIN, 32'd0, VAL_MAX);
      send_frame({4'd6, 48'h00_0000_0000_00});
      send_frame({4'd6, 48'hFF_FFFF_FFFF_FF});
      send_frame({4'd3, 48'hFF_FFFF_FFFF_FF});
      drain();

      // unused write data bits above the narrow registers
      program_registers(32'hA5A5_A5FF, 32'hFFFF_FFFF, 32'h0006_4800, -32'sd200000,
                        32'h0400_0000, 32'sd5000, 32'h0000_8000, -32'sd1);
      send_frame({4'd6, 48'hFF_ABCD_EF01_23});
      send_frame({4'd6, 48'hFE_ABCD_EF01_23});
      send_frame({4'd9, 48'hFF_ABCD_EF01_23});
      send_frame({4'd6, 48'hFF_0000_0FFF_00});

      for (phase = 0; phase < 6; phase++) begin
         drain();
         case (phase / 2)
            0: begin
               sender_idle_pct    = 10;
               receiver_stall_pct = 72;
            end
            1: begin
               sender_idle_pct    = 72;
               receiver_stall_pct = 10;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         program_registers(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom, $urandom,
                           pick_step(), pick_offset(), pick_step(), pick_offset(),
                           pick_step(), pick_offset());
         run_phase(PHASE_ITEMS);
      end
      drain();

      if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
         $display("[motor_feedback_frame_decoder] OK");
      end else begin
         $display("[motor_feedback_frame_decoder] ERROR");
      end
      $finish;
   end

endmodule
